[rtl/core/photon256_permutation_core_defines.svh]
// Assertion macros used by the PHOTON-256 permutation checker.
// No dependencies; the asserting module must have ports named clock and reset.
`ifndef PHOTON256_PERMUTATION_CORE_DEFINES_SVH
`define PHOTON256_PERMUTATION_CORE_DEFINES_SVH

// Check on every rising edge, reset included.
`define PH256_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Check on every rising edge outside reset.
`define PH256_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

[rtl/core/ph256_pkg.sv]
// Constants, types and round function of the PHOTON-256 permutation.
// No dependencies; imported by photon256_permutation_core.
package ph256_pkg;

   localparam int unsigned ROUNDS = 12;
   localparam int unsigned STATE_W = 256;

   typedef logic [STATE_W-1:0] state_type;
   typedef logic [3:0] cell_type;

   // reduction term of x^4 + x + 1
   localparam cell_type GF_RED = 4'h3;

   localparam cell_type SBOX [16] = '{
      4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
      4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2};

   localparam cell_type RCR [12] = '{
      4'd1, 4'd3, 4'd7, 4'd14, 4'd13, 4'd11, 4'd6, 4'd12, 4'd9, 4'd2, 4'd5, 4'd10};

   localparam cell_type ICV [8] = '{
      4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'he, 4'hc, 4'h8};

   localparam cell_type MIXM [8][8] = '{
      '{4'd2,  4'd4,  4'd2,  4'd11, 4'd2,  4'd8,  4'd5,  4'd6},
      '{4'd12, 4'd9,  4'd8,  4'd13, 4'd7,  4'd7,  4'd5,  4'd2},
      '{4'd4,  4'd4,  4'd13, 4'd13, 4'd9,  4'd4,  4'd13, 4'd9},
      '{4'd1,  4'd6,  4'd5,  4'd1,  4'd12, 4'd13, 4'd15, 4'd14},
      '{4'd15, 4'd12, 4'd9,  4'd13, 4'd14, 4'd5,  4'd14, 4'd13},
      '{4'd9,  4'd14, 4'd5,  4'd15, 4'd4,  4'd12, 4'd9,  4'd6},
      '{4'd12, 4'd2,  4'd2,  4'd10, 4'd3,  4'd1,  4'd1,  4'd14},
      '{4'd15, 4'd1,  4'd13, 4'd10, 4'd5,  4'd10, 4'd2,  4'd3}};

   function automatic cell_type gf16_mul(input cell_type a, input cell_type b);
      cell_type acc;
      cell_type x;
      acc = '0;
      x = a;
      for (int n = 0; n < 4; n++) begin
         if (b[n]) begin
            acc = acc ^ x;
         end
         x = x[3] ? ({x[2:0], 1'b0} ^ GF_RED) : {x[2:0], 1'b0};
      end
      return acc;
   endfunction

   // One full round; cell (r,c) sits at bit 32*r + 4*c.
   function automatic state_type photon_round(input state_type s, input int unsigned rnd);
      cell_type  a [8][8];
      cell_type  b [8][8];
      cell_type  acc;
      state_type res;
      res = '0;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            a[i][j] = s[32*i + 4*j +: 4];
         end
         a[i][0] = a[i][0] ^ RCR[rnd] ^ ICV[i];
         for (int j = 0; j < 8; j++) begin
            a[i][j] = SBOX[a[i][j]];
         end
      end
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            b[i][j] = a[i][3'(i + j)];
         end
      end
      for (int j = 0; j < 8; j++) begin
         for (int i = 0; i < 8; i++) begin
            acc = '0;
            for (int k = 0; k < 8; k++) begin
               acc = acc ^ gf16_mul(MIXM[i][k], b[k][j]);
            end
            res[32*i + 4*j +: 4] = acc;
         end
      end
      return res;
   endfunction

endpackage

[rtl/core/photon256_permutation_core.sv]
// PHOTON-256 permutation, fully unrolled with one round per pipeline stage.
// Depends on ph256_pkg (constants, round function).
//
// Usage:
//  - Request channel (req_valid / req_stall, four 64-bit row-pair words) takes one
//    256-bit state per transaction; cell (r,c) sits at bit 32*(r mod 2)+4*c of
//    word r/2.
//  - Response channel (rsp_valid / rsp_stall) returns the permuted state in the
//    same packing, one transaction per request, in request order.
//  - An accepted request passes through the stage registers in round order;
//    rsp_valid and the response come from the last stage register. Each stage
//    register holds one round: constant add, S-box, row rotation and the GF(16)
//    column mix.
//  - Throughput: one state per cycle without receiver stalls; stage registers set it.
//  - Stall: a stage advances when it is empty or the stage after it advances,
//    so bubbles collapse. req_stall rises only when every stage holds a
//    state and the receiver stalls the last one.
//  - Reset clears all stage valid bits; the pipeline then stands empty.
module photon256_permutation_core
   import ph256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_in_rows_0_1,
   input  logic [63:0] req_in_rows_2_3,
   input  logic [63:0] req_in_rows_4_5,
   input  logic [63:0] req_in_rows_6_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_rows_0_1,
   output logic [63:0] rsp_out_rows_2_3,
   output logic [63:0] rsp_out_rows_4_5,
   output logic [63:0] rsp_out_rows_6_7
);

   state_type st_ff  [ROUNDS];
   state_type st_in  [ROUNDS];
   logic      vld_ff [ROUNDS];
   logic      vld_in [ROUNDS];
   logic      ready  [ROUNDS+1];
   state_type req_state;

   // Gather the four row pairs into one state vector
   assign req_state = {req_in_rows_6_7, req_in_rows_4_5, req_in_rows_2_3, req_in_rows_0_1};

   // Last stage drains when the receiver takes the transaction
   assign ready[ROUNDS] = !rsp_stall;

   for (genvar g = 0; g < ROUNDS; g++) begin : g_stage
      state_type src_state;
      logic      src_vld;

      if (g == 0) begin : g_first
         assign src_state = req_state;
         assign src_vld   = req_valid;
      end else begin : g_next
         assign src_state = st_ff[g-1];
         assign src_vld   = vld_ff[g-1];
      end

      // Stage advances if empty or if its content moves on
      assign ready[g] = !vld_ff[g] || ready[g+1];

      always_comb begin
         vld_in[g] = ready[g] ? src_vld : vld_ff[g];
         st_in[g]  = st_ff[g];
         if (ready[g] && src_vld) begin
            st_in[g] = photon_round(src_state, g);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_in[g];
         end
      end

      // Payload holds while stalled; no reset needed
      always_ff @(posedge clock) begin
         st_ff[g] <= st_in[g];
      end
   end

   assign req_stall        = !ready[0];
   assign rsp_valid        = vld_ff[ROUNDS-1];
   assign rsp_out_rows_0_1 = st_ff[ROUNDS-1][63:0];
   assign rsp_out_rows_2_3 = st_ff[ROUNDS-1][127:64];
   assign rsp_out_rows_4_5 = st_ff[ROUNDS-1][191:128];
   assign rsp_out_rows_6_7 = st_ff[ROUNDS-1][255:192];

endmodule

[rtl/core/ph256_checker.sv]
// Port-level checker for photon256_permutation_core, bound into that module.
// Depends on photon256_permutation_core_defines.svh (assertion macros).
`include "photon256_permutation_core_defines.svh"

module ph256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_out_rows_0_1,
   input logic [63:0] rsp_out_rows_2_3,
   input logic [63:0] rsp_out_rows_4_5,
   input logic [63:0] rsp_out_rows_6_7
);

   // Pipeline empties on reset
   `PH256_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response valid after reset")

   // Backpressure reaches the requester only through a full, stalled pipeline
   `PH256_ASSERT_RUN(a_stall_source, req_stall |-> (rsp_valid && rsp_stall),
      "request stalled without a stalled response")

   // Stalled response transaction holds
   `PH256_ASSERT_RUN(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid &&
      $stable(rsp_out_rows_0_1) && $stable(rsp_out_rows_2_3) &&
      $stable(rsp_out_rows_4_5) && $stable(rsp_out_rows_6_7)),
      "stalled response changed")

   // Free-running receiver never backs up the request side
   `PH256_ASSERT_RUN(a_no_stall_free, (req_valid && !rsp_stall) |-> !req_stall,
      "request stalled while response side drains")

endmodule

bind photon256_permutation_core ph256_checker u_ph256_checker (.*);

[dv/photon256_permutation_core_test.sv]
// Self-checking testbench for photon256_permutation_core: PHOTON-256 permutation,
// directed and random states, checked against an independent round-by-round predictor.
// Depends on ph256_pkg (ROUNDS, for the drain wait) and the core RTL.
module photon256_permutation_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Full 256-bit state as the four row-pair words; rows01 sits in the low bits,
   // so cell (r,c) is bit 32*r + 4*c of the packed struct.
   typedef struct packed {
      bit [63:0] rows67;
      bit [63:0] rows45;
      bit [63:0] rows23;
      bit [63:0] rows01;
   } photon_state_type;

   typedef bit [3:0] nib_type;

   localparam int PERM_ROUNDS     = 12;
   localparam int RANDOM_ITEMS    = 1000;
   localparam int HOLD_OFF_CYCLES = 60;       // well beyond the 12 pipeline stages
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DIRECTED_COUNT  = 16;

   localparam nib_type SUBST [16] = '{
      4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
      4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2};
   localparam nib_type ROUND_CONST [12] = '{
      4'd1, 4'd3, 4'd7, 4'd14, 4'd13, 4'd11, 4'd6, 4'd12, 4'd9, 4'd2, 4'd5, 4'd10};
   localparam nib_type ROW_CONST [8] = '{
      4'h0, 4'h1, 4'h3, 4'h7, 4'hf, 4'he, 4'hc, 4'h8};
   localparam nib_type COLUMN_MIX [8][8] = '{
      '{4'd2,  4'd4,  4'd2,  4'd11, 4'd2,  4'd8,  4'd5,  4'd6},
      '{4'd12, 4'd9,  4'd8,  4'd13, 4'd7,  4'd7,  4'd5,  4'd2},
      '{4'd4,  4'd4,  4'd13, 4'd13, 4'd9,  4'd4,  4'd13, 4'd9},
      '{4'd1,  4'd6,  4'd5,  4'd1,  4'd12, 4'd13, 4'd15, 4'd14},
      '{4'd15, 4'd12, 4'd9,  4'd13, 4'd14, 4'd5,  4'd14, 4'd13},
      '{4'd9,  4'd14, 4'd5,  4'd15, 4'd4,  4'd12, 4'd9,  4'd6},
      '{4'd12, 4'd2,  4'd2,  4'd10, 4'd3,  4'd1,  4'd1,  4'd14},
      '{4'd15, 4'd1,  4'd13, 4'd10, 4'd5,  4'd10, 4'd2,  4'd3}};

   // Directed states, one row each: rows01, rows23, rows45, rows67.
   // The permutation has no result that can be read off by eye, so every row
   // goes through the predictor.
   localparam bit [63:0] DIRECTED_ROWS [DIRECTED_COUNT][4] = '{
      // all-zero and all-one states
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
      // alternating bit patterns
      '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
        64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
        64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA},
      // lowest and highest state bit alone
      '{64'h1, 64'h0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000},
      // edge bits of every word
      '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
        64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001},
      // every cell value along each row-pair word, both directions
      '{64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210,
        64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210},
      '{64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF,
        64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF},
      // column 0 saturated: the cells that take the round constant
      '{64'h0000_000F_0000_000F, 64'h0000_000F_0000_000F,
        64'h0000_000F_0000_000F, 64'h0000_000F_0000_000F},
      // column 0 equal to the first round and row constants: zero after the first add
      '{64'h0000_0000_0000_0001, 64'h0000_0006_0000_0002,
        64'h0000_000F_0000_000E, 64'h0000_0009_0000_000D},
      // even rows only, odd rows only
      '{64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF},
      '{64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000,
        64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000},
      // distinct words, to catch swapped row pairs
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0},
      // last cell alone
      '{64'h0, 64'h0, 64'h0, 64'hF000_0000_0000_0000},
      '{64'hDEAD_BEEF_CAFE_F00D, 64'h1357_9BDF_2468_ACE0,
        64'h8421_8421_1248_1248, 64'h7FFF_FFFF_FFFF_FFFE}};

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [63:0] req_in_rows_0_1  = '0;
   logic [63:0] req_in_rows_2_3  = '0;
   logic [63:0] req_in_rows_4_5  = '0;
   logic [63:0] req_in_rows_6_7  = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [63:0] rsp_out_rows_0_1;
   logic [63:0] rsp_out_rows_2_3;
   logic [63:0] rsp_out_rows_4_5;
   logic [63:0] rsp_out_rows_6_7;

   photon_state_type permuted_states [$];   // predicted outputs, oldest first
   int error_count   = 0;
   int rsp_seen      = 0;
   int tx_idle_pct   = 7;
   int rx_idle_pct   = 76;
   int holdoff_asked = 0;                // bumped by the stimulus
   int holdoff_taken = 0;                // owned by the receiver
   int holdoff_left  = 0;

   photon256_permutation_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_rows_0_1  (req_in_rows_0_1),
      .req_in_rows_2_3  (req_in_rows_2_3),
      .req_in_rows_4_5  (req_in_rows_4_5),
      .req_in_rows_6_7  (req_in_rows_6_7),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_rows_0_1 (rsp_out_rows_0_1),
      .rsp_out_rows_2_3 (rsp_out_rows_2_3),
      .rsp_out_rows_4_5 (rsp_out_rows_4_5),
      .rsp_out_rows_6_7 (rsp_out_rows_6_7)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Carry-less multiply in GF(16), reduce by x^4 + x + 1 on every shift.
   function automatic nib_type gf16_times(input nib_type a, input nib_type b);
      nib_type prod;
      nib_type x;
      prod = '0;
      x    = a;
      for (int n = 0; n < 4; n++) begin
         if (b[n]) begin
            prod = prod ^ x;
         end
         x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
      end
      return prod;
   endfunction

   // Predict the core's output: twelve rounds of constant add, S-box,
   // row rotation and column mix on the 8x8 cell grid.
   function automatic photon_state_type photon_permute(input photon_state_type st);
      nib_type          grid [8][8];
      nib_type          line [8];
      nib_type          acc;
      photon_state_type res;
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) begin
            grid[r][c] = st[32*r + 4*c +: 4];
         end
      end
      for (int rnd = 0; rnd < PERM_ROUNDS; rnd++) begin
         for (int r = 0; r < 8; r++) begin
            grid[r][0] = grid[r][0] ^ ROUND_CONST[rnd] ^ ROW_CONST[r];
            for (int c = 0; c < 8; c++) begin
               grid[r][c] = SUBST[grid[r][c]];
            end
         end
         // rotate row r left by r cells
         for (int r = 1; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
               line[c] = grid[r][(c + r) % 8];
            end
            for (int c = 0; c < 8; c++) begin
               grid[r][c] = line[c];
            end
         end
         for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 8; r++) begin
               acc = '0;
               for (int k = 0; k < 8; k++) begin
                  acc = acc ^ gf16_times(COLUMN_MIX[r][k], grid[k][c]);
               end
               line[r] = acc;
            end
            for (int r = 0; r < 8; r++) begin
               grid[r][c] = line[r];
            end
         end
      end
      res = '0;
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++) begin
            res[32*r + 4*c +: 4] = grid[r][c];
         end
      end
      return res;
   endfunction

   // Mostly uniform states; now and then a lone bit or a near-constant grid,
   // which keep the S-box and mix inputs far from uniform.
   function automatic photon_state_type random_state();
      photon_state_type st;
      int unsigned      kind;
      nib_type          fill;
      kind = $urandom_range(9);
      if (kind < 8) begin
         st.rows01 = {$urandom, $urandom};
         st.rows23 = {$urandom, $urandom};
         st.rows45 = {$urandom, $urandom};
         st.rows67 = {$urandom, $urandom};
      end else if (kind == 8) begin
         st = '0;
         st[$urandom_range(255)] = 1'b1;
      end else begin
         fill = 4'($urandom_range(15));
         st   = {64{fill}};
         st[4*$urandom_range(63) +: 4] = 4'($urandom);
      end
      return st;
   endfunction

   task automatic report_mismatch(input string what, input bit [63:0] got,
                                  input bit [63:0] want);
      $display("%0t ns: response %0d: %s got %h want %h", $time, rsp_seen, what, got, want);
      error_count++;
   endtask

   // Offer one state; entered and left at a falling edge. Idle a random number
   // of cycles first, then hold the payload until the core takes it.
   task automatic offer_state(input photon_state_type st);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_in_rows_0_1 <= st.rows01;
      req_in_rows_2_3 <= st.rows23;
      req_in_rows_4_5 <= st.rows45;
      req_in_rows_6_7 <= st.rows67;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      permuted_states.push_back(photon_permute(st));
      @(negedge clock);
   endtask

   // Receiver: drive rsp_stall at the falling edge. A hold-off request stalls
   // for a long stretch counted here, so the pipeline fills and backs up into
   // req_stall; otherwise stall at the current phase rate.
   always @(negedge clock) begin
      if (holdoff_left != 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_taken != holdoff_asked) begin
         rsp_stall     <= 1'b1;
         holdoff_left  <= HOLD_OFF_CYCLES - 1;
         holdoff_taken <= holdoff_taken + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      photon_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (permuted_states.size() == 0) begin
            report_mismatch("unexpected transaction, rows_0_1", rsp_out_rows_0_1, '0);
         end else begin
            want = permuted_states.pop_front();
            if (rsp_out_rows_0_1 !== want.rows01) begin
               report_mismatch("rows_0_1", rsp_out_rows_0_1, want.rows01);
            end
            if (rsp_out_rows_2_3 !== want.rows23) begin
               report_mismatch("rows_2_3", rsp_out_rows_2_3, want.rows23);
            end
            if (rsp_out_rows_4_5 !== want.rows45) begin
               report_mismatch("rows_4_5", rsp_out_rows_4_5, want.rows45);
            end
            if (rsp_out_rows_6_7 !== want.rows67) begin
               report_mismatch("rows_6_7", rsp_out_rows_6_7, want.rows67);
            end
         end
         rsp_seen++;
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("photon256_permutation_core_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      photon_state_type st;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: sender mostly busy, receiver stalls often.
      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         st = '{rows67: DIRECTED_ROWS[n][3], rows45: DIRECTED_ROWS[n][2],
                rows23: DIRECTED_ROWS[n][1], rows01: DIRECTED_ROWS[n][0]};
         offer_state(st);
      end
      repeat (RANDOM_ITEMS / 3) offer_state(random_state());

      // Phase 2: sender idles often, receiver rarely stalls.
      tx_idle_pct = 76;
      rx_idle_pct <= 7;
      repeat (RANDOM_ITEMS / 3) offer_state(random_state());

      // Phase 3: full rate both ways, opened by one long receiver hold-off
      // while the sender keeps pushing.
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      holdoff_asked <= holdoff_asked + 1;
      repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) offer_state(random_state());

      // Drain: drop valid, wait for every prediction, then idle longer than the pipeline depth.
      req_valid <= 1'b0;
      while (permuted_states.size() != 0) begin
         @(posedge clock);
      end
      repeat (ph256_pkg::ROUNDS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("photon256_permutation_core_test: done, clean");
      end else begin
         $display("photon256_permutation_core_test: done, errors");
      end
      $finish;
   end

endmodule

[photon256_permutation_core.f]
+incdir+rtl/core
rtl/core/ph256_pkg.sv
rtl/core/photon256_permutation_core.sv
rtl/core/ph256_checker.sv
dv/photon256_permutation_core_test.sv
